>>> rtl/dqb_pkg.sv
// Shared types, constants and byte tables for the DNS query builder.
package dqb_pkg;

  localparam int MaxLabel  = 56;
  localparam int LenW      = $clog2(MaxLabel + 1);
  localparam int AddrW     = $clog2(MaxLabel);
  localparam int HdrBytes  = 12;
  localparam int TailBytes = 5;
  localparam int CntW      = $clog2(HdrBytes);

  localparam logic [7:0] DotChar   = 8'h2E;
  localparam logic [7:0] FlagsHi   = 8'h01;
  localparam logic [7:0] QdCountLo = 8'h01;

  typedef logic [7:0]       byte_t;
  typedef logic [15:0]      word_t;
  typedef logic [AddrW-1:0] addr_t;
  typedef logic [LenW-1:0]  len_t;
  typedef logic [CntW-1:0]  cnt_t;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_QUERY_ID    = 2'd0,
    CFG_QUERY_TYPE  = 2'd1,
    CFG_QUERY_CLASS = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    word_t query_id;
    word_t query_type;
    word_t query_class;
  } cfg_t;

  // Label memory write request
  typedef struct packed {
    logic  we;
    addr_t addr;
    byte_t data;
  } ram_wr_t;

  // Sequencer status toward the top level
  typedef struct packed {
    logic idle;
    logic emit_last;
    len_t len;
  } seq_stat_t;

  // Header byte at position idx: id, flags 0x0100, one question, zero counts
  function automatic byte_t header_byte(input cnt_t idx, input word_t qid);
    byte_t b;
    b = '0;
    case (idx)
      cnt_t'(0): b = qid[15:8];
      cnt_t'(1): b = qid[7:0];
      cnt_t'(2): b = FlagsHi;
      cnt_t'(5): b = QdCountLo;
      default:   b = '0;
    endcase
    return b;
  endfunction

  // Trailer byte at position idx: root zero, type word, class word
  function automatic byte_t tail_byte(input cnt_t idx, input word_t qtype,
                                      input word_t qclass);
    byte_t b;
    b = '0;
    case (idx)
      cnt_t'(1): b = qtype[15:8];
      cnt_t'(2): b = qtype[7:0];
      cnt_t'(3): b = qclass[15:8];
      cnt_t'(4): b = qclass[7:0];
      default:   b = '0;
    endcase
    return b;
  endfunction

endpackage

>>> rtl/dqb_if.sv
// Request channel interfaces for host-name characters and message bytes.
interface dqb_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] name_char;
  logic       end_of_name;

  modport source (output valid, output name_char, output end_of_name, input ready);
  modport sink   (input valid, input name_char, input end_of_name, output ready);
endinterface

interface dqb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_byte;
  logic       truncated;

  modport source (output valid, output out_byte, output last_byte, output truncated,
                  input ready);
  modport sink   (input valid, input out_byte, input last_byte, input truncated,
                  output ready);
endinterface

>>> rtl/dns_query_builder.sv
// DNS query builder: turns a dotted host name into DNS query message bytes.
//
// A host name arrives one character per request on in_ch; the message leaves
// one byte per request on out_ch. The first character of a name brings the
// 12-byte header; each dot or the end of the name that closes a non-empty
// label brings the label length byte and the label, read back from a 56-entry
// label memory; the end of the name adds the root byte and the type and class
// words. While bytes are due the sequencer stays busy and emits them (12
// header, length plus label bytes, 5 trailer), paced by the single output
// register; a stalled output stalls it. Labels beyond 56 characters are cut
// and the truncated flag stays set for the rest of the name. The user must
// write configuration only while idle; the block itself does not enforce it.
module dns_query_builder (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [15:0]          cfg_wdata,
  dqb_in_if.sink               in_ch,
  dqb_out_if.source            out_ch
);
  import dqb_pkg::*;

  cfg_t      cfg_r;
  ram_wr_t   ram_wr;
  addr_t     ram_raddr;
  byte_t     ram_rdata;
  seq_stat_t stat;

  // Write configuration registers; ignore unused indexes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.query_id    <= 16'd2;
      cfg_r.query_type  <= 16'd1;
      cfg_r.query_class <= 16'd1;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_QUERY_ID:    cfg_r.query_id    <= cfg_wdata;
        CFG_QUERY_TYPE:  cfg_r.query_type  <= cfg_wdata;
        CFG_QUERY_CLASS: cfg_r.query_class <= cfg_wdata;
        default: ;
      endcase
    end
  end

  dqb_label_ram u_ram (
    .clk   (clk),
    .wr    (ram_wr),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  dqb_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_wr    (ram_wr),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .stat      (stat)
  );

  // Label writes happen only when a request is taken in idle
  a_wr_idle: assert property (@(posedge clk) disable iff (!rst_n)
    ram_wr.we |-> stat.idle)
    else $error("label write outside idle");

  // Held label length never exceeds the label limit
  a_len_bound: assert property (@(posedge clk) disable iff (!rst_n)
    stat.len <= len_t'(MaxLabel))
    else $error("label length beyond limit");

  // Emitting the final byte returns the block to accepting requests
  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit_last |=> in_ch.ready)
    else $error("not ready after final byte");

  // Emitting the final byte loads it, flagged last, into the output register
  a_last_after: assert property (@(posedge clk) disable iff (!rst_n)
    stat.emit_last |=> (out_ch.valid && out_ch.last_byte))
    else $error("final byte not presented");

endmodule

>>> rtl/dqb_label_ram.sv
// Label character memory: one write port, one registered read port.
module dqb_label_ram (
  input  logic             clk,
  input  dqb_pkg::ram_wr_t wr,
  input  dqb_pkg::addr_t   raddr,
  output dqb_pkg::byte_t   rdata
);
  import dqb_pkg::*;

  byte_t mem [MaxLabel];
  byte_t rdata_r;

  // Write the incoming character
  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
  end

  // Register the read data
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/dqb_seq.sv
// Message sequencer: takes characters, stores labels, emits query bytes.
module dqb_seq (
  input  logic               clk,
  input  logic               rst_n,
  input  dqb_pkg::cfg_t      cfg,
  dqb_in_if.sink             in_ch,
  dqb_out_if.source          out_ch,
  output dqb_pkg::ram_wr_t   ram_wr,
  output dqb_pkg::addr_t     ram_raddr,
  input  dqb_pkg::byte_t     ram_rdata,
  output dqb_pkg::seq_stat_t stat
);
  import dqb_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_HDR  = 5'b00010,
    ST_LEN  = 5'b00100,
    ST_LBL  = 5'b01000,
    ST_TAIL = 5'b10000
  } state_t;

  state_t state_r, state_nxt;
  cnt_t   cnt_r, cnt_nxt;
  addr_t  idx_r, idx_nxt;
  len_t   len_r, len_nxt;
  logic   hdr_sent_r, hdr_sent_nxt;
  logic   ovf_r, ovf_nxt;
  logic   flush_r, flush_nxt;
  logic   tail_r, tail_nxt;

  logic   out_valid_r;
  byte_t  out_byte_r;
  logic   out_last_r;
  logic   out_trunc_r;

  logic   accept;
  logic   can_emit;
  logic   is_dot;
  logic   store;
  len_t   len_after;
  logic   emit;
  byte_t  emit_byte;
  logic   emit_last;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign can_emit    = !out_valid_r || out_ch.ready;
  assign is_dot      = (in_ch.name_char == DotChar);
  assign store       = !is_dot && (len_r < len_t'(MaxLabel));
  assign len_after   = store ? len_r + len_t'(1) : len_r;

  // Sequence the header, length, label and trailer bytes
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    idx_nxt      = idx_r;
    len_nxt      = len_r;
    hdr_sent_nxt = hdr_sent_r;
    ovf_nxt      = ovf_r;
    flush_nxt    = flush_r;
    tail_nxt     = tail_r;
    emit         = 1'b0;
    emit_byte    = '0;
    emit_last    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          hdr_sent_nxt = 1'b1;
          if (!is_dot && !store) begin
            ovf_nxt = 1'b1;
          end
          len_nxt   = len_after;
          flush_nxt = (is_dot || in_ch.end_of_name) && (len_after != '0);
          tail_nxt  = in_ch.end_of_name;
          cnt_nxt   = '0;
          idx_nxt   = '0;
          if (!hdr_sent_r) begin
            state_nxt = ST_HDR;
          end else if ((is_dot || in_ch.end_of_name) && (len_after != '0)) begin
            state_nxt = ST_LEN;
          end else if (in_ch.end_of_name) begin
            state_nxt = ST_TAIL;
          end
        end
      end
      ST_HDR: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = header_byte(cnt_r, cfg.query_id);
          if (cnt_r == cnt_t'(HdrBytes - 1)) begin
            cnt_nxt = '0;
            if (flush_r) begin
              state_nxt = ST_LEN;
            end else if (tail_r) begin
              state_nxt = ST_TAIL;
            end else begin
              state_nxt = ST_IDLE;
            end
          end else begin
            cnt_nxt = cnt_r + cnt_t'(1);
          end
        end
      end
      ST_LEN: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = byte_t'(len_r);
          idx_nxt   = '0;
          state_nxt = ST_LBL;
        end
      end
      ST_LBL: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = ram_rdata;
          if (len_t'(idx_r) + len_t'(1) == len_r) begin
            idx_nxt   = '0;
            len_nxt   = '0;
            state_nxt = tail_r ? ST_TAIL : ST_IDLE;
          end else begin
            idx_nxt = idx_r + addr_t'(1);
          end
        end
      end
      ST_TAIL: begin
        if (can_emit) begin
          emit      = 1'b1;
          emit_byte = tail_byte(cnt_r, cfg.query_type, cfg.query_class);
          if (cnt_r == cnt_t'(TailBytes - 1)) begin
            emit_last    = 1'b1;
            cnt_nxt      = '0;
            len_nxt      = '0;
            hdr_sent_nxt = 1'b0;
            ovf_nxt      = 1'b0;
            state_nxt    = ST_IDLE;
          end else begin
            cnt_nxt = cnt_r + cnt_t'(1);
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      idx_r       <= '0;
      len_r       <= '0;
      hdr_sent_r  <= 1'b0;
      ovf_r       <= 1'b0;
      flush_r     <= 1'b0;
      tail_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      cnt_r      <= cnt_nxt;
      idx_r      <= idx_nxt;
      len_r      <= len_nxt;
      hdr_sent_r <= hdr_sent_nxt;
      ovf_r      <= ovf_nxt;
      flush_r    <= flush_nxt;
      tail_r     <= tail_nxt;
      if (emit) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Load the output register when a byte is emitted
  always_ff @(posedge clk) begin
    if (emit) begin
      out_byte_r  <= emit_byte;
      out_last_r  <= emit_last;
      out_trunc_r <= ovf_r;
    end
  end

  // Store characters; read one label byte ahead of its emission.
  // The first label read follows the length byte, so a write at accept
  // never collides with a read that is used.
  assign ram_wr.we   = accept && store;
  assign ram_wr.addr = addr_t'(len_r);
  assign ram_wr.data = in_ch.name_char;
  assign ram_raddr   = idx_nxt;

  assign out_ch.valid     = out_valid_r;
  assign out_ch.out_byte  = out_byte_r;
  assign out_ch.last_byte = out_last_r;
  assign out_ch.truncated = out_trunc_r;

  assign stat.idle      = (state_r == ST_IDLE);
  assign stat.emit_last = emit_last;
  assign stat.len       = len_r;

endmodule

>>> dv/dns_query_builder_test.sv
// Self-checking regression for the DNS query builder: directed rows, random names, checks.
module dns_query_builder_test;
  timeunit 1ns;
  timeprecision 1ps;

  import dqb_pkg::*;

  localparam int  CycleLimit  = 400000;
  localparam int  DrainCycles = 8;
  localparam int  HoldCycles  = 300;
  localparam int  MaxPrinted  = 30;
  localparam word_t RstQueryId    = 16'd2;
  localparam word_t RstQueryType  = 16'd1;
  localparam word_t RstQueryClass = 16'd1;
  // Register index past the three real registers; the block drops it
  localparam logic [1:0] CfgSpare = 2'd3;

  // One expected byte of the query message
  typedef struct packed {
    byte_t data;
    logic  is_last;
    logic  cut;
  } msg_byte_t;

  // Directed row: character, end flag, byte count it should produce
  typedef struct {
    byte_t ch;
    logic  eon;
    int    n_exp;
  } stim_row_t;

  localparam int NumRows = 19;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [15:0] cfg_wdata;

  dqb_in_if  in_if ();
  dqb_out_if out_if ();

  dns_query_builder u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata),
    .in_ch    (in_if),
    .out_ch   (out_if)
  );

  // Defaults after reset: empty name, label split, doubled, leading and
  // trailing dots, extreme character codes, trailer-only end of name
  stim_row_t dir_rows [NumRows] = '{
    '{DotChar, 1'b1, 17},  // empty name: header, root, type, class
    '{8'h61,   1'b0, 12},  // 'a' opens the header
    '{8'h62,   1'b0, 0},
    '{DotChar, 1'b0, 3},   // flush "ab"
    '{DotChar, 1'b0, 0},   // doubled dot adds nothing
    '{8'h63,   1'b1, 7},   // 'c' ends the name
    '{DotChar, 1'b0, 12},  // leading dot
    '{8'h78,   1'b1, 7},
    '{8'h71,   1'b0, 12},
    '{DotChar, 1'b1, 7},   // trailing dot closes the name
    '{8'h00,   1'b0, 12},
    '{8'hFF,   1'b0, 0},
    '{8'h2D,   1'b0, 0},
    '{8'h2F,   1'b0, 0},
    '{8'h80,   1'b0, 0},
    '{8'h7F,   1'b1, 12},
    '{DotChar, 1'b0, 12},
    '{DotChar, 1'b1, 5},   // header already out, empty label: trailer only
    '{8'h41,   1'b1, 19}   // one-character name
  };

  // Predictor state
  word_t     qid_reg    = RstQueryId;
  word_t     qtype_reg  = RstQueryType;
  word_t     qclass_reg = RstQueryClass;
  byte_t     lbl_mem [MaxLabel];
  int        lbl_len    = 0;
  logic      hdr_done   = 1'b0;
  logic      cut_seen   = 1'b0;
  msg_byte_t pending_bytes [$];

  // Run control and bookkeeping
  bit gaps_on    = 1'b1;
  bit hold_off   = 1'b0;
  int n_errors   = 0;
  int n_items    = 0;
  int n_names    = 0;
  int n_bytes    = 0;
  int n_cut      = 0;
  int n_settings = 0;
  int cycle_cnt  = 0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  task automatic report_mismatch(input string what);
    if (n_errors < MaxPrinted) $display("%0t ns  MISMATCH: %s", $time, what);
    n_errors++;
  endtask

  // Append one message byte, tagged with the current cut flag
  function automatic void put_msg_byte(input byte_t b, input logic is_last);
    pending_bytes.push_back('{data: b, is_last: is_last, cut: cut_seen});
  endfunction

  // Emit length byte and held characters of the current label, if any
  function automatic void emit_label();
    if (lbl_len != 0) begin
      put_msg_byte(byte_t'(lbl_len), 1'b0);
      for (int i = 0; i < lbl_len; i++) put_msg_byte(lbl_mem[i], 1'b0);
      lbl_len = 0;
    end
  endfunction

  // Work out the message bytes one accepted character causes
  function automatic int predict_query_bytes(input byte_t c, input logic eon);
    int n_prior;
    n_prior = pending_bytes.size();
    if (!hdr_done) begin
      put_msg_byte(qid_reg[15:8], 1'b0);
      put_msg_byte(qid_reg[7:0], 1'b0);
      put_msg_byte(FlagsHi, 1'b0);
      put_msg_byte(8'h00, 1'b0);
      put_msg_byte(8'h00, 1'b0);
      put_msg_byte(QdCountLo, 1'b0);
      for (int i = 6; i < HdrBytes; i++) put_msg_byte(8'h00, 1'b0);
      hdr_done = 1'b1;
    end
    if (c == DotChar) begin
      emit_label();
    end else if (lbl_len < MaxLabel) begin
      lbl_mem[lbl_len] = c;
      lbl_len++;
    end else begin
      cut_seen = 1'b1;
    end
    if (eon) begin
      emit_label();
      put_msg_byte(8'h00, 1'b0);
      put_msg_byte(qtype_reg[15:8], 1'b0);
      put_msg_byte(qtype_reg[7:0], 1'b0);
      put_msg_byte(qclass_reg[15:8], 1'b0);
      put_msg_byte(qclass_reg[7:0], 1'b1);
      hdr_done = 1'b0;
      cut_seen = 1'b0;
      lbl_len  = 0;
    end
    return pending_bytes.size() - n_prior;
  endfunction

  // Offer one character, with an optional idle gap, and predict on accept
  task automatic send_char(input byte_t c, input logic eon, output int n_made);
    int gap;
    gap = 0;
    while (gaps_on && $urandom_range(0, 99) < 26) gap++;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid       <= 1'b1;
    in_if.name_char   <= c;
    in_if.end_of_name <= eon;
    @(posedge clk);
    while (in_if.ready !== 1'b1) @(posedge clk);
    n_made = predict_query_bytes(c, eon);
    n_items++;
    if (eon) n_names++;
  endtask

  // Build one host name, mostly well formed, and send it
  task automatic send_name(input bit force_long);
    byte_t name_q [$];
    byte_t c;
    int    n_lbl;
    int    len;
    int    n_made;
    if (!force_long && $urandom_range(0, 7) == 0) begin
      // Broken name: raw bytes with plenty of dots
      len = $urandom_range(1, 6);
      repeat (len) begin
        c = ($urandom_range(0, 3) == 0) ? DotChar : byte_t'($urandom_range(0, 255));
        name_q.push_back(c);
      end
    end else begin
      if ($urandom_range(0, 7) == 0) name_q.push_back(DotChar);
      n_lbl = force_long ? 2 : $urandom_range(0, 4);
      for (int i = 0; i < n_lbl; i++) begin
        if (force_long) len = MaxLabel + i;
        else if ($urandom_range(0, 24) == 0) len = $urandom_range(MaxLabel - 1, MaxLabel + 3);
        else len = $urandom_range(1, 10);
        repeat (len) begin
          c = byte_t'($urandom_range(0, 255));
          if (c == DotChar) c = 8'h2D;
          name_q.push_back(c);
        end
        if (i < n_lbl - 1 || $urandom_range(0, 5) == 0) name_q.push_back(DotChar);
        if ($urandom_range(0, 9) == 0) name_q.push_back(DotChar);
      end
      if (name_q.size() == 0) name_q.push_back(DotChar);
    end
    foreach (name_q[k]) send_char(name_q[k], k == name_q.size() - 1, n_made);
  endtask

  task automatic run_names(input int quota);
    int start_n;
    start_n = n_items;
    while (n_items - start_n < quota) send_name(1'b0);
    in_if.valid <= 1'b0;
  endtask

  // Hold until every expected byte is out, then let the block settle
  task automatic wait_drained();
    while (pending_bytes.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input word_t val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    case (idx)
      CFG_QUERY_ID:    qid_reg    = val;
      CFG_QUERY_TYPE:  qtype_reg  = val;
      CFG_QUERY_CLASS: qclass_reg = val;
      default: ;
    endcase
  endtask

  task automatic set_config(input word_t qid, input word_t qtype, input word_t qclass);
    wait_drained();
    write_reg(CFG_QUERY_ID, qid);
    write_reg(CFG_QUERY_TYPE, qtype);
    write_reg(CFG_QUERY_CLASS, qclass);
    write_reg(CfgSpare, word_t'($urandom_range(0, 65535)));
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  // Result side: random stalls, plus one long hold-off on request
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off) begin
        out_if.ready <= 1'b0;
        repeat (HoldCycles - 1) @(posedge clk);
        hold_off = 1'b0;
      end else begin
        out_if.ready <= !(gaps_on && $urandom_range(0, 99) < 26);
      end
    end
  end

  // Compare each accepted byte with the oldest expectation
  always @(posedge clk) begin
    msg_byte_t want;
    if (rst_n === 1'b1 && out_if.valid === 1'b1 && out_if.ready === 1'b1) begin
      n_bytes++;
      if (out_if.truncated === 1'b1) n_cut++;
      if (pending_bytes.size() == 0) begin
        report_mismatch($sformatf("unexpected byte %02h", out_if.out_byte));
      end else begin
        want = pending_bytes.pop_front();
        if (out_if.out_byte !== want.data)
          report_mismatch($sformatf("out_byte %02h, want %02h", out_if.out_byte, want.data));
        if (out_if.last_byte !== want.is_last)
          report_mismatch($sformatf("last_byte %b, want %b", out_if.last_byte, want.is_last));
        if (out_if.truncated !== want.cut)
          report_mismatch($sformatf("truncated %b, want %b", out_if.truncated, want.cut));
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt <= CycleLimit) begin
      @(posedge clk);
      cycle_cnt++;
    end
    $display("timeout after %0d cycles, %0d bytes still expected", cycle_cnt,
             pending_bytes.size());
    $display("dns_query_builder regression: fail");
    $finish;
  end

  initial begin
    int n_made;
    rst_n             <= 1'b0;
    cfg_we            <= 1'b0;
    cfg_index         <= CFG_QUERY_ID;
    cfg_wdata         <= '0;
    in_if.valid       <= 1'b0;
    in_if.name_char   <= '0;
    in_if.end_of_name <= 1'b0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows under reset register values
    foreach (dir_rows[r]) begin
      send_char(dir_rows[r].ch, dir_rows[r].eon, n_made);
      if (dir_rows[r].n_exp >= 0 && n_made != dir_rows[r].n_exp)
        report_mismatch($sformatf("row %0d gives %0d bytes, want %0d", r, n_made,
                                  dir_rows[r].n_exp));
    end
    in_if.valid <= 1'b0;

    // Extreme words; labels right at and one past the limit
    set_config(16'hFFFF, 16'h0000, 16'hFFFF);
    send_name(1'b1);
    run_names(12);

    // Opposite extremes, no idling on either side
    gaps_on = 1'b0;
    set_config(16'h0000, 16'hFFFF, 16'h0000);
    run_names(12);

    // Random words; long hold-off on the result side to back up the input
    gaps_on = 1'b1;
    set_config(word_t'($urandom_range(0, 65535)), word_t'($urandom_range(0, 65535)),
               word_t'($urandom_range(0, 65535)));
    hold_off = 1'b1;
    run_names(12);

    set_config(word_t'($urandom_range(0, 65535)), word_t'($urandom_range(0, 65535)),
               word_t'($urandom_range(0, 65535)));
    run_names(12);

    wait_drained();
    $display("covered %0d characters in %0d names over %0d register settings", n_items,
             n_names, n_settings + 1);
    $display("checked %0d message bytes, %0d of them flagged truncated, %0d mismatches",
             n_bytes, n_cut, n_errors);
    if (n_errors == 0) $display("dns_query_builder regression: pass");
    else $display("dns_query_builder regression: fail");
    $finish;
  end

endmodule
